// ----- design/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants for the stepper pulse generator
// Command codes, widths and the word passed from front to back.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int PRESCALE      = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SPEED   = 2'd1;
    localparam logic [1:0] CMD_MEASURE = 2'd2;

    localparam logic [1:0] REG_CLOCK   = 2'd0;
    localparam logic [1:0] REG_MICRO   = 2'd1;
    localparam logic [1:0] REG_RATE    = 2'd2;

    // Classified word from the front end
    typedef struct packed {
        logic [1:0]  cmd;
        logic        sel;
        logic        neg;
        logic [29:0] freq;   // |speed| * microsteps, zero mapped to one
    } spg_cmd_t;

endpackage

// ----- design/spg_front.sv -----
// ----------------------------------------------------------------------------
// spg_front: input stage and command queue
// Takes input words, forms the step frequency and queues the classified word.
// ----------------------------------------------------------------------------
module spg_front
    import spg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic        in_sel,
    input  logic [20:0] in_speed,
    input  logic [8:0]  micro,
    output logic        q_valid,
    input  logic        q_ready,
    output spg_cmd_t    q_word
);
    spg_cmd_t   mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [20:0] mag;
    logic [29:0] prod;
    spg_cmd_t    word_in;
    logic        push, pop;

    // Magnitude times microstep factor
    always_comb begin
        mag  = in_speed[20] ? (~in_speed + 21'd1) : in_speed;
        prod = 30'(mag) * 30'(micro);
        word_in.cmd  = in_cmd;
        word_in.sel  = in_sel;
        word_in.neg  = in_speed[20];
        word_in.freq = (prod == 30'd0) ? 30'd1 : prod;
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= word_in;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- design/spg_divider.sv -----
// ----------------------------------------------------------------------------
// spg_divider: radix-2 restoring divider
// Unsigned 64 by 64 bit divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spg_divider
    import spg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg, rem_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb begin
        shifted = {rem_reg, quo_reg[63]};
        trial   = shifted - {1'b0, den_reg};
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // One bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= 64'd0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule

// ----- design/spg_back.sv -----
// ----------------------------------------------------------------------------
// spg_back: motor state and command execution
// Runs ticks, speed updates (two divides) and measurements; holds the result.
// ----------------------------------------------------------------------------
module spg_back
    import spg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  spg_cmd_t     q_word,
    input  logic [31:0]  clock_hz,
    input  logic [15:0]  rate,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [119:0] out_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV1, ST_CMP, ST_MUL, ST_DIV2, ST_MEAS, ST_AVG, ST_OUT
    } state_t;

    state_t      state_reg;
    spg_cmd_t    cur_reg;
    logic [COUNTER_WIDTH-1:0] cnt_reg [2];
    logic [COUNTER_WIDTH-1:0] lim_reg [2];
    logic [1:0]  lvl_reg, dir_set_reg, rev_reg;
    logic [31:0] steps_reg [2];
    logic [31:0] spd_reg [3];
    logic [COUNTER_WIDTH-1:0] cmp_reg;
    logic [47:0] mul_reg [2];
    logic        out_valid_reg;
    logic [119:0] out_data_reg;

    logic        div_start, div_done;
    logic [63:0] div_a, div_b, div_q;
    logic [COUNTER_WIDTH-1:0] cmp_sat;
    logic [31:0] sat [2];
    logic signed [32:0] avg_sum;

    localparam logic [63:0] CntMax = 64'((65'd1 << COUNTER_WIDTH) - 65'd1);

    // Divider operand select
    always_comb begin
        div_start = 1'b0;
        div_a = 64'(clock_hz);
        div_b = 64'(PRESCALE) * 64'(cur_reg.freq);
        if (state_reg == ST_IDLE && q_valid && q_word.cmd == CMD_SPEED &&
            !out_valid_reg) begin
            div_start = 1'b1;
            div_a = 64'(clock_hz);
            div_b = 64'(PRESCALE) * 64'(q_word.freq);
        end else if (state_reg == ST_MUL) begin
            div_start = 1'b1;
            div_a = 64'(cnt_reg[cur_reg.sel]) * 64'(cmp_reg);
            div_b = 64'(lim_reg[cur_reg.sel]);
        end
    end

    spg_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    // Compare value from the quotient, saturated
    always_comb begin
        if (div_q == 64'd0)               cmp_sat = '0;
        else if (div_q - 64'd1 > CntMax)  cmp_sat = '1;
        else                              cmp_sat = COUNTER_WIDTH'(div_q - 64'd1);
    end

    // Measured speeds: product/32 toward zero, saturated
    always_comb begin
        logic signed [47:0] p, v;
        for (int m = 0; m < 2; m++) begin
            p = signed'(mul_reg[m]);
            v = (p < 0) ? -((-p) >>> 5) : (p >>> 5);
            if (v > 48'sd2147483647)       sat[m] = 32'h7fffffff;
            else if (v < -48'sd2147483648) sat[m] = 32'h80000000;
            else                           sat[m] = v[31:0];
        end
        avg_sum = 33'(signed'(spd_reg[0])) + 33'(signed'(spd_reg[1]));
    end

    assign q_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and motor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lvl_reg       <= 2'b00;
            dir_set_reg   <= 2'b00;
            rev_reg       <= 2'b00;
            for (int m = 0; m < 2; m++) begin
                cnt_reg[m]   <= '0;
                lim_reg[m]   <= '1;
                steps_reg[m] <= 32'd0;
            end
            for (int k = 0; k < 3; k++) spd_reg[k] <= 32'd0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid && !out_valid_reg) begin
                        cur_reg <= q_word;
                        unique case (q_word.cmd)
                            CMD_TICK: begin
                                for (int m = 0; m < 2; m++) begin
                                    if (cnt_reg[m] >= lim_reg[m]) begin
                                        cnt_reg[m] <= '0;
                                        lvl_reg[m] <= ~lvl_reg[m];
                                        if (dir_set_reg[m])
                                            steps_reg[m] <= rev_reg[m] ?
                                                steps_reg[m] - 32'd1 :
                                                steps_reg[m] + 32'd1;
                                    end else begin
                                        cnt_reg[m] <= cnt_reg[m] + 1'b1;
                                    end
                                end
                                state_reg <= ST_OUT;
                            end
                            CMD_SPEED:   state_reg <= ST_DIV1;
                            CMD_MEASURE: begin
                                for (int m = 0; m < 2; m++)
                                    mul_reg[m] <= 48'(signed'(steps_reg[m])) *
                                                  signed'(48'(rate));
                                state_reg <= ST_MEAS;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_DIV1: if (div_done) state_reg <= ST_CMP;
                ST_CMP: begin
                    cmp_reg   <= cmp_sat;
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_DIV2;
                ST_DIV2: begin
                    if (div_done) begin
                        if (lim_reg[cur_reg.sel] == '0) cnt_reg[cur_reg.sel] <= '0;
                        else cnt_reg[cur_reg.sel] <= COUNTER_WIDTH'(div_q);
                        lim_reg[cur_reg.sel]     <= cmp_reg;
                        dir_set_reg[cur_reg.sel] <= 1'b1;
                        rev_reg[cur_reg.sel]     <= cur_reg.neg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_MEAS: begin
                    spd_reg[0]   <= sat[0];
                    spd_reg[1]   <= sat[1];
                    steps_reg[0] <= 32'd0;
                    steps_reg[1] <= 32'd0;
                    state_reg    <= ST_AVG;
                end
                ST_AVG: begin
                    spd_reg[2] <= (avg_sum < 0) ? 32'(-((-avg_sum) >>> 1))
                                                : 32'(avg_sum >>> 1);
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {4'd0, 16'(lim_reg[cur_reg.sel]), spd_reg[2],
                                      spd_reg[1], spd_reg[0],
                                      rev_reg[1] & dir_set_reg[1],
                                      rev_reg[0] & dir_set_reg[0],
                                      lvl_reg[1], lvl_reg[0]};
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- design/stepper_pulse_generator.sv -----
// A tick passes ST_IDLE and ST_OUT to its result word, a measurement ST_MEAS
// and ST_AVG before ST_OUT, a speed setting two passes of the bit-serial 64-bit
// divider (ST_DIV1, ST_CMP, ST_MUL, ST_DIV2). The back end takes one word at a
// time and no new word until its result is taken; a two-word queue buffers input.
// Reset (aresetn low, synchronous): counters 0, compares 65535, counts and
// speeds 0, directions unset, registers to defaults.
// ----------------------------------------------------------------------------
// stepper_pulse_generator: two-channel stepper step pulse generator
// Front queue feeds a back end holding motor state and a shared divider.
// ----------------------------------------------------------------------------
module stepper_pulse_generator
    import spg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // command[1:0], motor_select[2], speed_value[23:3]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // step_left[0], step_right[1], dir_left[2],
                                    // dir_right[3], speed_left[35:4],
                                    // speed_right[67:36], speed_average[99:68],
                                    // period_compare[115:100]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [31:0] clock_reg;
    logic [8:0]  micro_reg;
    logic [15:0] rate_reg;
    logic        q_valid, q_ready;
    spg_cmd_t    q_word;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= 32'd48000000;
            micro_reg <= 9'd16;
            rate_reg  <= 16'd100;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CLOCK: clock_reg <= cfg_data;
                REG_MICRO: micro_reg <= cfg_data[8:0];
                REG_RATE:  rate_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    spg_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_sel(s_tdata[2]), .in_speed(s_tdata[23:3]),
        .micro(micro_reg), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    spg_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word), .clock_hz(clock_reg), .rate(rate_reg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );
endmodule

// ----- design/spg_checker.sv -----
// ----------------------------------------------------------------------------
// spg_checker: port-level checks for the stepper pulse generator
// Output handshake and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module spg_checker
    import spg_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && $past(!aresetn, 2) |-> m_tdata[115:100] == 16'hffff)
        else $error("compare not at reset value");
endmodule

bind stepper_pulse_generator spg_checker u_spg_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);
